FILE: hw/rtl/ppv_pkg.sv
`default_nettype none

package ppv_pkg;

   // default fixed-point layout
   localparam int PPV_FRAC_BITS  = 16;
   localparam int PPV_COEF_WIDTH = 32;

   // x, y, z lanes through the divider
   localparam int PPV_AXES = 3;

   typedef enum logic [1:0] {
      OP_LOAD_MV   = 2'd0,
      OP_LOAD_PROJ = 2'd1,
      OP_PROJECT   = 2'd2
   } ppv_op_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } ppv_csr_type;

   typedef logic signed [31:0] ppv_word_type;
   typedef ppv_word_type [3:0] ppv_vec_type;

   typedef struct packed {
      ppv_op_type         op;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } ppv_req_type;

   typedef struct packed {
      logic signed [31:0] window_x;
      logic signed [31:0] window_y;
      logic signed [31:0] depth;
      logic               w_was_zero;
      logic               saturated;
   } ppv_rsp_type;

   // item control traveling with the matrix stages
   typedef struct packed {
      ppv_op_type         op;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic               sat;
   } ppv_side_type;

   // item control traveling with the divider
   typedef struct packed {
      logic w_was_zero;
      logic sat;
   } ppv_div_side_type;

   localparam logic signed [65:0] PPV_SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] PPV_SAT_MIN = -66'sd2147483648;

   function automatic ppv_word_type ppv_sat(input logic signed [65:0] v);
      ppv_word_type r;
      if (v > PPV_SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < PPV_SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ppv_sat_hit(input logic signed [65:0] v);
      return (v > PPV_SAT_MAX) || (v < PPV_SAT_MIN);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppv_matvec.sv
`default_nettype none

module ppv_matvec #(
   parameter int                  FRAC_BITS  = ppv_pkg::PPV_FRAC_BITS,
   parameter int                  COEF_WIDTH = ppv_pkg::PPV_COEF_WIDTH,
   parameter ppv_pkg::ppv_op_type TABLE_OP   = ppv_pkg::OP_LOAD_MV
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire ppv_pkg::ppv_side_type in_side,
   input  wire ppv_pkg::ppv_vec_type  in_vec,
   output logic                       out_valid,
   output ppv_pkg::ppv_side_type      out_side,
   output ppv_pkg::ppv_vec_type       out_vec
);
   import ppv_pkg::*;

   localparam int CW_EFF = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
   localparam int TW     = (CW_EFF > FRAC_BITS + 1) ? CW_EFF : FRAC_BITS + 2;
   localparam int PW     = TW + 32;
   localparam int P1W    = PW + 1;
   localparam int SW     = PW + 2;
   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);
   localparam logic signed [PW-1:0] HALF  = PW'(64'd1 << (FRAC_BITS - 1));

   logic signed [TW-1:0]  table_ff [16];
   logic signed [TW-1:0]  coef_in;
   logic                  table_we;

   logic signed [PW-1:0]  prod_ff [16];
   logic signed [PW-1:0]  prod_in [16];
   logic signed [PW-1:0]  rnd_ff  [16];
   logic signed [PW-1:0]  rnd_in  [16];
   logic signed [P1W-1:0] pair_ff [8];
   logic signed [P1W-1:0] pair_in [8];
   logic signed [SW-1:0]  sum_v   [4];
   ppv_vec_type           out_vec_ff;
   ppv_vec_type           out_vec_in;
   logic                  ovf_in;

   logic                  v1_ff, v2_ff, v3_ff, out_valid_ff;
   ppv_side_type          s1_ff, s2_ff, s3_ff, out_side_ff, out_side_in;

   // coefficient keeps its low bits, sign extended
   assign coef_in  = TW'($signed(in_side.coef_value[CW_EFF-1:0]));
   assign table_we = advance && in_valid && (in_side.op == TABLE_OP);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            table_ff[k] <= ((k % 5) == 0) ? ONE_T : '0;
         end
      end else if (table_we) begin
         table_ff[in_side.coef_index] <= coef_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i*4+j] = PW'(table_ff[i*4+j]) * PW'($signed(in_vec[j]));
         end
      end
      for (int k = 0; k < 16; k++) begin
         rnd_in[k] = (prod_ff[k] + HALF) >>> FRAC_BITS;
      end
      for (int i = 0; i < 4; i++) begin
         pair_in[i*2]   = P1W'(rnd_ff[i*4])   + P1W'(rnd_ff[i*4+1]);
         pair_in[i*2+1] = P1W'(rnd_ff[i*4+2]) + P1W'(rnd_ff[i*4+3]);
      end
      ovf_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sum_v[i]      = SW'(pair_ff[i*2]) + SW'(pair_ff[i*2+1]);
         out_vec_in[i] = ppv_sat(66'(sum_v[i]));
         ovf_in        = ovf_in | ppv_sat_hit(66'(sum_v[i]));
      end
      out_side_in     = s3_ff;
      out_side_in.sat = s3_ff.sat | ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= prod_in;
         rnd_ff      <= rnd_in;
         pair_ff     <= pair_in;
         out_vec_ff  <= out_vec_in;
         s1_ff       <= in_side;
         s2_ff       <= s1_ff;
         s3_ff       <= s2_ff;
         out_side_ff <= out_side_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_vec   = out_vec_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_div.sv
`default_nettype none

module ppv_div #(
   parameter int FRAC_BITS = ppv_pkg::PPV_FRAC_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [32+FRAC_BITS-1:0] in_num [ppv_pkg::PPV_AXES],
   input  wire logic [31:0]             in_den,
   input  wire logic                    in_neg [ppv_pkg::PPV_AXES],
   input  wire ppv_pkg::ppv_div_side_type in_side,
   output logic                         out_valid,
   output logic [32+FRAC_BITS-1:0]      out_quo [ppv_pkg::PPV_AXES],
   output logic                         out_neg [ppv_pkg::PPV_AXES],
   output ppv_pkg::ppv_div_side_type    out_side
);
   import ppv_pkg::*;

   localparam int NQ = 32 + FRAC_BITS;

   // one quotient bit per stage, restoring
   logic             stg_valid_ff [NQ];
   logic [31:0]      stg_rem_ff   [NQ][PPV_AXES];
   logic [NQ-1:0]    stg_num_ff   [NQ][PPV_AXES];
   logic [31:0]      stg_den_ff   [NQ];
   logic             stg_neg_ff   [NQ][PPV_AXES];
   ppv_div_side_type stg_side_ff  [NQ];

   for (genvar s = 0; s < NQ; s++) begin : g_step
      logic             prev_valid;
      logic [31:0]      prev_rem  [PPV_AXES];
      logic [NQ-1:0]    prev_num  [PPV_AXES];
      logic [31:0]      prev_den;
      logic             prev_neg  [PPV_AXES];
      ppv_div_side_type prev_side;
      logic [31:0]      rem_in    [PPV_AXES];
      logic [NQ-1:0]    num_in    [PPV_AXES];

      if (s == 0) begin : g_first
         always_comb begin
            prev_valid = in_valid;
            prev_den   = in_den;
            prev_side  = in_side;
            for (int l = 0; l < PPV_AXES; l++) begin
               prev_rem[l] = '0;
               prev_num[l] = in_num[l];
               prev_neg[l] = in_neg[l];
            end
         end
      end else begin : g_next
         always_comb begin
            prev_valid = stg_valid_ff[s-1];
            prev_den   = stg_den_ff[s-1];
            prev_side  = stg_side_ff[s-1];
            for (int l = 0; l < PPV_AXES; l++) begin
               prev_rem[l] = stg_rem_ff[s-1][l];
               prev_num[l] = stg_num_ff[s-1][l];
               prev_neg[l] = stg_neg_ff[s-1][l];
            end
         end
      end

      always_comb begin
         logic [32:0] t;
         logic        ge;
         for (int l = 0; l < PPV_AXES; l++) begin
            t          = {prev_rem[l], prev_num[l][NQ-1]};
            ge         = (t >= {1'b0, prev_den});
            rem_in[l]  = ge ? 32'(t - {1'b0, prev_den}) : t[31:0];
            num_in[l]  = {prev_num[l][NQ-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[s] <= 1'b0;
         end else if (advance) begin
            stg_valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stg_den_ff[s]  <= prev_den;
            stg_side_ff[s] <= prev_side;
            for (int l = 0; l < PPV_AXES; l++) begin
               stg_rem_ff[s][l] <= rem_in[l];
               stg_num_ff[s][l] <= num_in[l];
               stg_neg_ff[s][l] <= prev_neg[l];
            end
         end
      end
   end

   always_comb begin
      out_valid = stg_valid_ff[NQ-1];
      out_side  = stg_side_ff[NQ-1];
      for (int l = 0; l < PPV_AXES; l++) begin
         out_quo[l] = stg_num_ff[NQ-1][l];
         out_neg[l] = stg_neg_ff[NQ-1][l];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/project_point_to_viewport_core.sv
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  ppv_req_type: op, coefficient, point
// rsp       out        rsp_valid / rsp_stall  ppv_rsp_type: window x/y, depth, flags
// csr       in         csr_we                 csr_index, csr_wdata (viewport)
//
// one item per cycle unless held; a project item's result passes the input register,
// both matrix units, divider prep, the one-bit-per-stage divider, ndc, map and output
// loads and unused op codes give no result and leave only bubbles
// the whole pipeline holds while a result waits under rsp_stall
// sync reset restores identity matrices and a 640 x 480 viewport at the origin

module project_point_to_viewport_core #(
   parameter int FRAC_BITS  = ppv_pkg::PPV_FRAC_BITS,
   parameter int COEF_WIDTH = ppv_pkg::PPV_COEF_WIDTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire ppv_pkg::ppv_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output ppv_pkg::ppv_rsp_type rsp_data,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);
   import ppv_pkg::*;

   localparam int NQ = 32 + FRAC_BITS;
   localparam logic signed [31:0] ONE_W = 32'(64'd1 << FRAC_BITS);

   // whole pipeline moves together unless the output is held
   logic advance;

   // viewport registers
   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [13:0]        width_ff, height_ff;

   // input stage
   logic         in_valid_ff;
   ppv_req_type  in_ff;
   ppv_side_type mv1_side;
   ppv_vec_type  mv1_vec;

   // matrix stages
   logic         mv1_valid, mv2_valid;
   ppv_side_type mv1_side_out, mv2_side_out;
   ppv_vec_type  eye_vec, clip_vec;

   // divider prep
   logic               dp_valid_ff, dp_valid_in;
   logic [NQ-1:0]      dp_num_ff [PPV_AXES];
   logic [NQ-1:0]      dp_num_in [PPV_AXES];
   logic [31:0]        dp_den_ff, dp_den_in;
   logic               dp_neg_ff [PPV_AXES];
   logic               dp_neg_in [PPV_AXES];
   ppv_div_side_type   dp_side_ff, dp_side_in;

   // divider out
   logic               dv_valid;
   logic [NQ-1:0]      dv_quo [PPV_AXES];
   logic               dv_neg [PPV_AXES];
   ppv_div_side_type   dv_side;

   // ndc stage
   logic               ndc_valid_ff;
   ppv_word_type       ndc_ff [PPV_AXES];
   ppv_word_type       ndc_in [PPV_AXES];
   ppv_div_side_type   ndc_side_ff, ndc_side_in;

   // viewport multiply stage
   logic               map_valid_ff;
   logic signed [47:0] map_px_ff, map_px_in, map_py_ff, map_py_in;
   ppv_word_type       map_dz_ff, map_dz_in;
   ppv_div_side_type   map_side_ff, map_side_in;

   // output register
   logic               rsp_valid_ff;
   ppv_rsp_type        rsp_ff, rsp_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // config writes, to be made only while idle; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= 14'd640;
         height_ff   <= 14'd480;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= $signed(csr_wdata);
            CSR_ORIGIN_Y: origin_y_ff <= $signed(csr_wdata);
            CSR_WIDTH:    width_ff    <= csr_wdata[13:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[13:0];
            default:      ;
         endcase
      end
   end

   // input register, one transfer per cycle when not held
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_data;
      end
   end

   // homogeneous point with w of one
   always_comb begin
      mv1_side.op         = in_ff.op;
      mv1_side.coef_index = in_ff.coef_index;
      mv1_side.coef_value = in_ff.coef_value;
      mv1_side.sat        = 1'b0;
      mv1_vec[0]          = in_ff.point_x;
      mv1_vec[1]          = in_ff.point_y;
      mv1_vec[2]          = in_ff.point_z;
      mv1_vec[3]          = ONE_W;
   end

   // model-view: loads of op OP_LOAD_MV land in its table on the way through
   ppv_matvec #(
      .FRAC_BITS  (FRAC_BITS),
      .COEF_WIDTH (COEF_WIDTH),
      .TABLE_OP   (OP_LOAD_MV)
   ) u_modelview (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_valid_ff),
      .in_side   (mv1_side),
      .in_vec    (mv1_vec),
      .out_valid (mv1_valid),
      .out_side  (mv1_side_out),
      .out_vec   (eye_vec)
   );

   // projection: same structure, loads of op OP_LOAD_PROJ written here
   ppv_matvec #(
      .FRAC_BITS  (FRAC_BITS),
      .COEF_WIDTH (COEF_WIDTH),
      .TABLE_OP   (OP_LOAD_PROJ)
   ) u_projection (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mv1_valid),
      .in_side   (mv1_side_out),
      .in_vec    (eye_vec),
      .out_valid (mv2_valid),
      .out_side  (mv2_side_out),
      .out_vec   (clip_vec)
   );

   // divider prep: zero w becomes one, split into sign and magnitude,
   // only project items go on from here
   always_comb begin
      logic signed [31:0] w;
      logic signed [31:0] wv;
      logic signed [31:0] c;
      logic               wz;
      w                     = $signed(clip_vec[3]);
      wz                    = (w == 32'sd0);
      wv                    = wz ? ONE_W : w;
      dp_den_in             = wv[31] ? 32'(-wv) : 32'(wv);
      dp_valid_in           = mv2_valid && (mv2_side_out.op == OP_PROJECT);
      dp_side_in.w_was_zero = wz;
      dp_side_in.sat        = mv2_side_out.sat;
      for (int l = 0; l < PPV_AXES; l++) begin
         c            = $signed(clip_vec[l]);
         dp_num_in[l] = {(c[31] ? 32'(-c) : 32'(c)), {FRAC_BITS{1'b0}}};
         dp_neg_in[l] = c[31] ^ wv[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_valid_ff <= 1'b0;
      end else if (advance) begin
         dp_valid_ff <= dp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dp_den_ff  <= dp_den_in;
         dp_side_ff <= dp_side_in;
         dp_num_ff  <= dp_num_in;
         dp_neg_ff  <= dp_neg_in;
      end
   end

   ppv_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dp_valid_ff),
      .in_num    (dp_num_ff),
      .in_den    (dp_den_ff),
      .in_neg    (dp_neg_ff),
      .in_side   (dp_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg),
      .out_side  (dv_side)
   );

   // signed quotient, truncated toward zero, clamped to the word
   always_comb begin
      logic signed [65:0] q;
      logic               hit;
      hit = 1'b0;
      for (int l = 0; l < PPV_AXES; l++) begin
         q         = 66'({1'b0, dv_quo[l]});
         q         = dv_neg[l] ? -q : q;
         ndc_in[l] = ppv_sat(q);
         hit       = hit | ppv_sat_hit(q);
      end
      ndc_side_in     = dv_side;
      ndc_side_in.sat = dv_side.sat | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndc_valid_ff <= 1'b0;
      end else if (advance) begin
         ndc_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ndc_ff      <= ndc_in;
         ndc_side_ff <= ndc_side_in;
      end
   end

   // (ndc + 1) * size; depth is only halved, it cannot leave the word
   always_comb begin
      logic signed [32:0] ax, ay;
      logic signed [65:0] dz;
      ax        = 33'($signed(ndc_ff[0])) + 33'(ONE_W);
      ay        = 33'($signed(ndc_ff[1])) + 33'(ONE_W);
      map_px_in = 48'(ax) * 48'($signed({1'b0, width_ff}));
      map_py_in = 48'(ay) * 48'($signed({1'b0, height_ff}));
      dz        = (66'($signed(ndc_ff[2])) + 66'(ONE_W) + 66'sd1) >>> 1;
      map_dz_in = ppv_sat(dz);
      map_side_in     = ndc_side_ff;
      map_side_in.sat = ndc_side_ff.sat | ppv_sat_hit(dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else if (advance) begin
         map_valid_ff <= ndc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         map_px_ff   <= map_px_in;
         map_py_ff   <= map_py_in;
         map_dz_ff   <= map_dz_in;
         map_side_ff <= map_side_in;
      end
   end

   // halve with round half up, add the origin in pixels
   always_comb begin
      logic signed [65:0] sx, sy;
      sx = ((66'(map_px_ff) + 66'sd1) >>> 1) + (66'(origin_x_ff) <<< FRAC_BITS);
      sy = ((66'(map_py_ff) + 66'sd1) >>> 1) + (66'(origin_y_ff) <<< FRAC_BITS);
      rsp_in.window_x   = ppv_sat(sx);
      rsp_in.window_y   = ppv_sat(sy);
      rsp_in.depth      = map_dz_ff;
      rsp_in.w_was_zero = map_side_ff.w_was_zero;
      rsp_in.saturated  = map_side_ff.sat | ppv_sat_hit(sx) | ppv_sat_hit(sy);
   end

   // output register, held while the transfer is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= map_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: sim/ppv_checker.sv
`default_nettype none

module ppv_checker
   import ppv_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_stall,
   input  wire ppv_req_type req_data,
   input  wire logic   rsp_valid,
   input  wire logic   rsp_stall,
   input  wire ppv_rsp_type rsp_data,
   input  wire logic   csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          proj_count,
   output int          load_count,
   output int          wzero_count,
   output int          sat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE  = longint'(1) <<< PPV_FRAC_BITS;
   localparam longint HALF = longint'(1) <<< (PPV_FRAC_BITS - 1);
   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;

   longint mv_tab [16];
   longint pj_tab [16];
   longint org_x, org_y, vp_w, vp_h;
   ppv_rsp_type window_q [$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      proj_count  = 0;
      load_count  = 0;
      wzero_count = 0;
      sat_count   = 0;
   end

   function automatic longint clamp(input longint v, inout bit hit);
      if (v > WMAX) begin
         hit = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         hit = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b + HALF) >>> PPV_FRAC_BITS;
   endfunction

   function automatic longint map_axis(input longint ndc, input longint size,
                                       input longint origin, inout bit hit);
      longint s;
      s = (ndc + ONE) * size;
      return clamp(((s + 1) >>> 1) + origin * ONE, hit);
   endfunction

   function automatic ppv_rsp_type project_point(input ppv_req_type r);
      longint p [4];
      longint eye [4];
      longint clip [4];
      longint ndc [3];
      longint acc, w;
      bit hit;
      ppv_rsp_type o;
      hit = 1'b0;
      p[0] = longint'(r.point_x);
      p[1] = longint'(r.point_y);
      p[2] = longint'(r.point_z);
      p[3] = ONE;
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int j = 0; j < 4; j++) acc += fx_mul(mv_tab[i*4+j], p[j]);
         eye[i] = clamp(acc, hit);
      end
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int j = 0; j < 4; j++) acc += fx_mul(pj_tab[i*4+j], eye[j]);
         clip[i] = clamp(acc, hit);
      end
      w = clip[3];
      o.w_was_zero = (w == 0);
      if (w == 0) w = ONE;
      for (int i = 0; i < 3; i++) ndc[i] = clamp((clip[i] * ONE) / w, hit);
      o.window_x = map_axis(ndc[0], vp_w, org_x, hit);
      o.window_y = map_axis(ndc[1], vp_h, org_y, hit);
      o.depth    = clamp((ndc[2] + ONE + 1) >>> 1, hit);
      o.saturated = hit;
      return o;
   endfunction

   task automatic report(input string field, input longint got, input longint want);
      fail_count++;
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
   endtask

   always @(posedge clock) begin
      ppv_rsp_type want;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mv_tab[i] = (i % 5 == 0) ? ONE : 0;
            pj_tab[i] = (i % 5 == 0) ? ONE : 0;
         end
         org_x = 0;
         org_y = 0;
         vp_w  = 640;
         vp_h  = 480;
         window_q.delete();
      end else begin
         if (csr_we) begin
            case (ppv_csr_type'(csr_index))
               CSR_ORIGIN_X: org_x = longint'($signed(csr_wdata));
               CSR_ORIGIN_Y: org_y = longint'($signed(csr_wdata));
               CSR_WIDTH:    vp_w  = longint'(csr_wdata[13:0]);
               CSR_HEIGHT:   vp_h  = longint'(csr_wdata[13:0]);
               default:      ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.op)
               OP_LOAD_MV: begin
                  mv_tab[req_data.coef_index] = longint'(req_data.coef_value);
                  load_count++;
               end
               OP_LOAD_PROJ: begin
                  pj_tab[req_data.coef_index] = longint'(req_data.coef_value);
                  load_count++;
               end
               OP_PROJECT: begin
                  want = project_point(req_data);
                  window_q.push_back(want);
                  proj_count++;
                  if (want.w_was_zero) wzero_count++;
                  if (want.saturated) sat_count++;
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (window_q.size() == 0) begin
               report("unexpected transfer", 0, 0);
            end else begin
               want = window_q.pop_front();
               if (rsp_data.window_x !== want.window_x)
                  report("window_x", rsp_data.window_x, want.window_x);
               if (rsp_data.window_y !== want.window_y)
                  report("window_y", rsp_data.window_y, want.window_y);
               if (rsp_data.depth !== want.depth)
                  report("depth", rsp_data.depth, want.depth);
               if (rsp_data.w_was_zero !== want.w_was_zero)
                  report("w_was_zero", rsp_data.w_was_zero, want.w_was_zero);
               if (rsp_data.saturated !== want.saturated)
                  report("saturated", rsp_data.saturated, want.saturated);
            end
         end
      end
      pending = window_q.size();
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
   import ppv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CYCLE_LIMIT = 400000;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     RANDOM_ITEMS = 150;  // per random phase
   localparam longint ONE = longint'(1) <<< PPV_FRAC_BITS;
   localparam ppv_op_type OP_UNUSED = ppv_op_type'(2'd3);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ppv_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ppv_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int fail_count, pending, proj_count, load_count, wzero_count, sat_count;
   int send_pct, recv_pct;
   int cycles = 0;
   int csr_writes = 0;

   project_point_to_viewport_core u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   ppv_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending, .proj_count, .load_count, .wzero_count, .sat_count
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
         $display("[project_point_to_viewport_core] ERROR");
         $finish;
      end
   end

   // result side backpressure, rerolled every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   // all tasks start and end just after a falling edge

   // one transfer on req, with random idle cycles ahead of it
   task automatic send(input ppv_req_type item);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop sending and let every owed window result come back, then let loads clear
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input ppv_csr_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_viewport(input logic [15:0] ox, input logic [15:0] oy,
                               input logic [15:0] vw, input logic [15:0] vh);
      drain();
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_WIDTH, vw);
      csr_write(CSR_HEIGHT, vh);
   endtask

   task automatic load(input ppv_op_type op, input int idx, input longint value);
      ppv_req_type item;
      item = '0;
      item.op = op;
      item.coef_index = idx[3:0];
      item.coef_value = value[31:0];
      item.point_x = $urandom;
      item.point_y = $urandom;
      item.point_z = $urandom;
      send(item);
   endtask

   task automatic project(input longint x, input longint y, input longint z);
      ppv_req_type item;
      item.op = OP_PROJECT;
      item.coef_index = 4'($urandom);
      item.coef_value = $urandom;
      item.point_x = x[31:0];
      item.point_y = y[31:0];
      item.point_z = z[31:0];
      send(item);
   endtask

   // both matrices back to identity
   task automatic load_identity();
      for (int i = 0; i < 16; i++) begin
         load(OP_LOAD_MV, i, (i % 5 == 0) ? ONE : 0);
         load(OP_LOAD_PROJ, i, (i % 5 == 0) ? ONE : 0);
      end
   endtask

   // coefficients lean toward zero and unit so that w hits zero now and then
   function automatic longint pick_coef();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return 0;
      if (roll < 45) return ($urandom_range(1)) ? ONE : -ONE;
      if (roll < 90) return longint'($urandom_range(1 << 19)) - (1 << 18);
      return longint'($signed($urandom));
   endfunction

   // mostly modest points, some anywhere in the full range
   function automatic longint pick_coord();
      if ($urandom_range(99) < 80) return longint'($urandom_range(1 << 22)) - (1 << 21);
      return longint'($signed($urandom));
   endfunction

   task automatic random_item();
      int roll;
      ppv_req_type item;
      roll = $urandom_range(99);
      if (roll < 2) begin
         load_identity();
      end else if (roll < 12) begin
         load(OP_LOAD_MV, $urandom_range(15), pick_coef());
      end else if (roll < 22) begin
         load(OP_LOAD_PROJ, $urandom_range(15), pick_coef());
      end else if (roll < 25) begin
         item.op = OP_UNUSED;
         item.coef_index = 4'($urandom);
         item.coef_value = $urandom;
         item.point_x = $urandom;
         item.point_y = $urandom;
         item.point_z = $urandom;
         send(item);
      end else begin
         project(pick_coord(), pick_coord(), pick_coord());
      end
   endtask

   task automatic random_phase(input int s_pct, input int r_pct);
      send_pct = s_pct;
      recv_pct = r_pct;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         random_item();
         // a stretch with no idling inside each phase
         if (n == RANDOM_ITEMS / 2) begin
            send_pct = 0;
            recv_pct = 0;
         end
         if (n == RANDOM_ITEMS / 2 + 30) begin
            send_pct = s_pct;
            recv_pct = r_pct;
         end
         // hold off until the pipe is empty
         if (n == RANDOM_ITEMS / 3) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      send_pct = 19;
      recv_pct = 53;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset viewport, identity matrices
      project(0, 0, 0);
      project(64'sh7fffffff, -64'sh80000000, 0);
      project(ONE, -ONE, ONE / 2);
      project(-64'sh80000000, 64'sh7fffffff, 64'sh7fffffff);
      load(OP_UNUSED, 5, 64'sh12345678);
      project(3 * ONE, 2 * ONE, -ONE);
      // zero clip w
      load(OP_LOAD_PROJ, 15, 0);
      project(ONE / 4, -ONE / 4, ONE / 8);
      // perspective row: w = -z
      load(OP_LOAD_PROJ, 14, -ONE);
      project(ONE, ONE / 2, -2 * ONE);
      project(ONE, ONE, 0);
      load(OP_LOAD_PROJ, 14, 0);
      load(OP_LOAD_PROJ, 15, ONE);
      // extreme coefficients in the model-view translation column
      load(OP_LOAD_MV, 3, 64'sh7fffffff);
      load(OP_LOAD_MV, 7, -64'sh80000000);
      project(0, 0, 0);
      load(OP_LOAD_MV, 3, 0);
      load(OP_LOAD_MV, 7, 0);
      load(OP_LOAD_MV, 0, 2 * ONE);
      project(ONE / 2, ONE / 2, ONE / 2);
      load(OP_LOAD_MV, 0, ONE);

      set_viewport(16'h8000, 16'h7fff, 16'd1, 16'd8192);
      project(-ONE, ONE, -ONE);
      project(ONE, -ONE, ONE);
      random_phase(19, 53);

      set_viewport(16'h7fff, 16'h8000, 16'd0, 16'h3fff);
      project(ONE, ONE, ONE);
      random_phase(53, 19);

      set_viewport(16'($urandom), 16'($urandom), 16'($urandom_range(1, 8192)),
                   16'($urandom_range(1, 8192)));
      random_phase(0, 0);

      drain();
      $display("%0d window results checked (%0d with zero w, %0d clamped), %0d coefficient loads,",
               proj_count, wzero_count, sat_count, load_count);
      $display("%0d viewport register writes across reset, extreme and random settings",
               csr_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("[project_point_to_viewport_core] OK");
      end else begin
         $display("[project_point_to_viewport_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
